### src/assert_macros.svh
// assertion macros shared by the checker files
// expects clk and arst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds, consequent in the same cycle
`define PC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent holds, consequent in the next cycle
`define PC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/pc_pkg.sv
// polygon centroid package: widths, codes and the controller/datapath interface types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pc_pkg;

	localparam int CW      = 16;          // coordinate and origin width
	localparam int CNT_W   = 11;          // vertex count width
	localparam int PROD_W  = 2 * CW + 2;  // 17 x 17 signed product
	localparam int CROSS_W = 44;
	localparam int WSUM_W  = 62;
	localparam int DEN_W   = CROSS_W + 2; // three times the cross sum
	localparam int DNUM_W  = WSUM_W + 1;  // rounded divider numerator

	localparam logic REG_ORIGIN_X = 1'b0;
	localparam logic REG_ORIGIN_Y = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_ZERO_AREA = 2'd1,
		ST_OVERFLOW  = 2'd2
	} status_t;

	// multiply sequence of one edge
	typedef enum logic [2:0] {
		MS_P_XY   = 3'd0,
		MS_P_YX   = 3'd1,
		MS_CROSS  = 3'd2,
		MS_WX_LO  = 3'd3,
		MS_WX_HI  = 3'd4,
		MS_WY_LO  = 3'd5,
		MS_WY_HI  = 3'd6,
		MS_WY_ACC = 3'd7
	} mstep_t;

	typedef struct packed {
		logic   take;
		logic   load_vertex;
		logic   load_closing;
		logic   mul_en;
		mstep_t mul_step;
		logic   den_load;
		logic   div_start;
		logic   div_sel_y;
		logic   cap_x;
		logic   cap_y;
		logic   result_load;
	} pc_cmd_t;

	typedef struct packed {
		logic last;
		logic count_zero;
		logic full;
		logic overflowed;
		logic count_ge3;
		logic cross_zero;
		logic div_done;
		logic out_free;
	} pc_stat_t;

endpackage

`default_nettype wire

### src/pc_div.sv
// bit-serial restoring divider with round-to-nearest, ties away from zero
// depends on pc_pkg
`timescale 1ns / 1ps
`default_nettype none

module pc_div
	import pc_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic signed [WSUM_W-1:0] num,
	input  wire logic signed [DEN_W-1:0]  den,
	output logic                          done,
	output logic [DNUM_W-1:0]             quot,
	output logic                          neg
);

	localparam int DCNT_W = $clog2(DNUM_W);

	typedef enum logic [1:0] {D_IDLE, D_PREP, D_RUN} dstate_t;

	dstate_t             st_q;
	logic [WSUM_W-1:0]   mn_q;
	logic [DEN_W-1:0]    md_q;
	logic                neg_q;
	logic [DNUM_W-1:0]   nq_q;
	logic [DEN_W:0]      dv_q;
	logic [DEN_W:0]      r_q;
	logic [DCNT_W-1:0]   cnt_q;
	logic                done_q;

	logic [DEN_W+1:0]    r2;
	logic [DEN_W+1:0]    rdiff;
	logic                ge;
	logic [DEN_W:0]      r_nxt;

	always_comb begin
		r2    = {r_q, nq_q[DNUM_W-1]};
		rdiff = r2 - {1'b0, dv_q};
		ge    = (r2 >= {1'b0, dv_q});
		r_nxt = ge ? rdiff[DEN_W:0] : r2[DEN_W:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= D_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				D_IDLE: begin
					if (start) begin
						mn_q  <= num[WSUM_W-1] ? WSUM_W'(-num) : WSUM_W'(num);
						md_q  <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
						neg_q <= num[WSUM_W-1] ^ den[DEN_W-1];
						st_q  <= D_PREP;
					end
				end
				D_PREP: begin
					nq_q  <= {mn_q, 1'b0} + DNUM_W'(md_q);
					dv_q  <= {md_q, 1'b0};
					r_q   <= '0;
					cnt_q <= DCNT_W'(DNUM_W - 1);
					st_q  <= D_RUN;
				end
				D_RUN: begin
					r_q  <= r_nxt;
					nq_q <= {nq_q[DNUM_W-2:0], ge};
					if (cnt_q == '0) begin
						st_q   <= D_IDLE;
						done_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: st_q <= D_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign quot = nq_q;
	assign neg  = neg_q;

endmodule

`default_nettype wire

### src/pc_dp.sv
// polygon centroid datapath: vertex registers, shared multiplier, shoelace sums,
// result formatting and output register; depends on pc_pkg and pc_div
`timescale 1ns / 1ps
`default_nettype none

module pc_dp
	import pc_pkg::*;
#(
	parameter int MAX_VERTICES = 1024,
	parameter int COORD_WIDTH  = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_index,
	input  wire logic [CW-1:0]        cfg_data,
	input  wire logic signed [CW-1:0] vertex_x,
	input  wire logic signed [CW-1:0] vertex_y,
	input  wire logic                 last_vertex,
	input  wire logic                 centroid_stall,
	output logic                      centroid_valid,
	output logic signed [CW-1:0]      centroid_x,
	output logic signed [CW-1:0]      centroid_y,
	output logic [1:0]                status,
	output logic [CNT_W-1:0]          vertices_seen,
	input  wire pc_cmd_t              cmd,
	output pc_stat_t                  stat
);

	localparam int SH = CW - COORD_WIDTH;

	logic signed [CW-1:0]      ox_q, oy_q;
	logic signed [CW-1:0]      vx_q, vy_q;
	logic                      last_q;
	logic signed [CW-1:0]      fx_q, fy_q, px_q, py_q;
	logic signed [CW-1:0]      ex0_q, ey0_q, ex1_q, ey1_q;
	logic [CNT_W-1:0]          count_q;
	logic                      ovf_q;
	logic signed [CW:0]        sx_q, sy_q;
	logic signed [2*CW-1:0]    c_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [CROSS_W-1:0] cross_q;
	logic signed [WSUM_W-1:0]  wx_q, wy_q;
	logic signed [DEN_W-1:0]   den_q;
	logic signed [CW+1:0]      qx_q, qy_q;

	logic                      out_valid_q;
	logic signed [CW-1:0]      out_x_q, out_y_q;
	status_t                   out_st_q;
	logic [CNT_W-1:0]          out_cnt_q;

	logic signed [CW-1:0]      vx_sh, vy_sh, vx_ext, vy_ext;
	logic signed [CW:0]        ma, mb;
	logic signed [2*CW-1:0]    c_new;
	logic                      full, cross_zero, count_ge3, out_free;
	logic                      div_done, div_neg;
	logic [DNUM_W-1:0]         div_quot;
	logic signed [CW+1:0]      q_clamp;
	logic signed [CW+1:0]      cx_sel, cy_sel;
	status_t                   st_sel;

	function automatic logic signed [CW+1:0] half_round(input logic signed [CW:0] s);
		logic [CW:0]   m;
		logic [CW+1:0] t;
		logic [CW:0]   h;
		m = s[CW] ? (CW+1)'(-s) : (CW+1)'(s);
		t = {1'b0, m} + (CW+2)'(1);
		h = t[CW+1:1];
		return s[CW] ? -$signed({1'b0, h}) : $signed({1'b0, h});
	endfunction

	function automatic logic signed [CW-1:0] sat16(input logic signed [CW+2:0] v);
		logic signed [CW+2:0] hi;
		logic signed [CW+2:0] lo;
		hi = (CW+3)'(2 ** (CW - 1) - 1);
		lo = -(CW+3)'(2 ** (CW - 1));
		if (v > hi) return hi[CW-1:0];
		if (v < lo) return lo[CW-1:0];
		return v[CW-1:0];
	endfunction

	always_comb begin
		vx_sh  = vertex_x << SH;
		vy_sh  = vertex_y << SH;
		vx_ext = vx_sh >>> SH;
		vy_ext = vy_sh >>> SH;
	end

	assign full       = (count_q >= CNT_W'(MAX_VERTICES));
	assign cross_zero = (cross_q == '0);
	assign count_ge3  = (count_q >= CNT_W'(3));
	assign out_free   = !out_valid_q || !centroid_stall;
	assign c_new      = c_q - prod_q[2*CW-1:0];

	always_comb begin
		stat.last       = last_q;
		stat.count_zero = (count_q == '0);
		stat.full       = full;
		stat.overflowed = ovf_q;
		stat.count_ge3  = count_ge3;
		stat.cross_zero = cross_zero;
		stat.div_done   = div_done;
		stat.out_free   = out_free;
	end

	// shared multiplier operands
	always_comb begin
		case (cmd.mul_step)
			MS_P_XY: begin
				ma = {ex0_q[CW-1], ex0_q};
				mb = {ey1_q[CW-1], ey1_q};
			end
			MS_P_YX: begin
				ma = {ex1_q[CW-1], ex1_q};
				mb = {ey0_q[CW-1], ey0_q};
			end
			MS_WX_LO: begin
				ma = sx_q;
				mb = {1'b0, c_q[CW-1:0]};
			end
			MS_WX_HI: begin
				ma = sx_q;
				mb = {c_q[2*CW-1], c_q[2*CW-1:CW]};
			end
			MS_WY_LO: begin
				ma = sy_q;
				mb = {1'b0, c_q[CW-1:0]};
			end
			MS_WY_HI: begin
				ma = sy_q;
				mb = {c_q[2*CW-1], c_q[2*CW-1:CW]};
			end
			default: begin
				ma = {ex0_q[CW-1], ex0_q};
				mb = {ey1_q[CW-1], ey1_q};
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			vx_q   <= vx_ext;
			vy_q   <= vy_ext;
			last_q <= last_vertex;
		end
		if (cmd.load_vertex && !full) begin
			ex0_q <= px_q;
			ey0_q <= py_q;
			ex1_q <= vx_q;
			ey1_q <= vy_q;
		end
		if (cmd.load_closing) begin
			ex0_q <= px_q;
			ey0_q <= py_q;
			ex1_q <= fx_q;
			ey1_q <= fy_q;
		end
		if (cmd.mul_en) begin
			prod_q <= PROD_W'(ma * mb);
			case (cmd.mul_step)
				MS_P_XY: begin
					sx_q <= {ex0_q[CW-1], ex0_q} + {ex1_q[CW-1], ex1_q};
					sy_q <= {ey0_q[CW-1], ey0_q} + {ey1_q[CW-1], ey1_q};
				end
				MS_P_YX:  c_q <= prod_q[2*CW-1:0];
				MS_CROSS: c_q <= c_new;
				default: ;
			endcase
		end
		if (cmd.den_load) begin
			den_q <= {{2{cross_q[CROSS_W-1]}}, cross_q}
				+ {cross_q[CROSS_W-1], cross_q, 1'b0};
		end
		if (cmd.cap_x) qx_q <= q_clamp;
		if (cmd.cap_y) qy_q <= q_clamp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ox_q    <= '0;
			oy_q    <= '0;
			fx_q    <= '0;
			fy_q    <= '0;
			px_q    <= '0;
			py_q    <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
			cross_q <= '0;
			wx_q    <= '0;
			wy_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ORIGIN_X: ox_q <= cfg_data;
					REG_ORIGIN_Y: oy_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.load_vertex) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					if (count_q == '0) begin
						fx_q <= vx_q;
						fy_q <= vy_q;
					end
					px_q    <= vx_q;
					py_q    <= vy_q;
					count_q <= count_q + 1'b1;
				end
			end
			if (cmd.mul_en) begin
				case (cmd.mul_step)
					MS_CROSS: cross_q <= cross_q + {{(CROSS_W-2*CW){c_new[2*CW-1]}}, c_new};
					MS_WX_HI: wx_q <= wx_q + {{(WSUM_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
					MS_WY_LO: wx_q <= wx_q
						+ {{(WSUM_W-PROD_W-CW){prod_q[PROD_W-1]}}, prod_q, {CW{1'b0}}};
					MS_WY_HI: wy_q <= wy_q + {{(WSUM_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
					MS_WY_ACC: wy_q <= wy_q
						+ {{(WSUM_W-PROD_W-CW){prod_q[PROD_W-1]}}, prod_q, {CW{1'b0}}};
					default: ;
				endcase
			end
			if (cmd.result_load) begin
				fx_q    <= '0;
				fy_q    <= '0;
				px_q    <= '0;
				py_q    <= '0;
				count_q <= '0;
				ovf_q   <= 1'b0;
				cross_q <= '0;
				wx_q    <= '0;
				wy_q    <= '0;
			end
		end
	end

	pc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (cmd.div_sel_y ? wy_q : wx_q),
		.den    (den_q),
		.done   (div_done),
		.quot   (div_quot),
		.neg    (div_neg)
	);

	// quotient clamped well past the output range
	always_comb begin
		logic [CW:0] m;
		m = (|div_quot[DNUM_W-1:CW+1]) ? '1 : div_quot[CW:0];
		q_clamp = div_neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
	end

	always_comb begin
		cx_sel = '0;
		cy_sel = '0;
		st_sel = ST_OK;
		if (ovf_q) begin
			st_sel = ST_OVERFLOW;
		end else if (count_q == CNT_W'(2)) begin
			cx_sel = half_round({fx_q[CW-1], fx_q} + {px_q[CW-1], px_q});
			cy_sel = half_round({fy_q[CW-1], fy_q} + {py_q[CW-1], py_q});
		end else if (count_ge3) begin
			if (cross_zero) begin
				st_sel = ST_ZERO_AREA;
			end else begin
				cx_sel = qx_q;
				cy_sel = qy_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.result_load) begin
			out_x_q   <= sat16({cx_sel[CW+1], cx_sel} + {{3{ox_q[CW-1]}}, ox_q});
			out_y_q   <= sat16({cy_sel[CW+1], cy_sel} + {{3{oy_q[CW-1]}}, oy_q});
			out_st_q  <= st_sel;
			out_cnt_q <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.result_load) begin
			out_valid_q <= 1'b1;
		end else if (!centroid_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign centroid_valid = out_valid_q;
	assign centroid_x     = out_x_q;
	assign centroid_y     = out_y_q;
	assign status         = out_st_q;
	assign vertices_seen  = out_cnt_q;

endmodule

`default_nettype wire

### src/pc_ctrl.sv
// polygon centroid controller: per-vertex edge sequence, closing edge, divides, result
// depends on pc_pkg
`timescale 1ns / 1ps
`default_nettype none

module pc_ctrl
	import pc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     vertex_valid,
	input  wire pc_stat_t stat,
	output pc_cmd_t       cmd,
	output logic          vertex_stall
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD,
		S_MUL,
		S_CHECK,
		S_AREA,
		S_DSTX,
		S_DIVX,
		S_DIVY,
		S_RESULT
	} state_t;

	state_t state_q;
	mstep_t step_q;
	logic   closing_q;

	always_comb begin
		cmd          = '0;
		cmd.mul_step = step_q;
		case (state_q)
			S_IDLE:  cmd.take = vertex_valid;
			S_LOAD:  cmd.load_vertex = 1'b1;
			S_MUL:   cmd.mul_en = 1'b1;
			S_CHECK: cmd.load_closing = stat.last && !stat.overflowed && stat.count_ge3;
			S_AREA:  cmd.den_load = !stat.cross_zero;
			S_DSTX:  cmd.div_start = 1'b1;
			S_DIVX: begin
				if (stat.div_done) begin
					cmd.cap_x     = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel_y = 1'b1;
				end
			end
			S_DIVY:   cmd.cap_y = stat.div_done;
			S_RESULT: cmd.result_load = stat.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			step_q    <= MS_P_XY;
			closing_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (vertex_valid) state_q <= S_LOAD;
				end
				S_LOAD: begin
					if (!stat.full && !stat.count_zero) begin
						state_q   <= S_MUL;
						step_q    <= MS_P_XY;
						closing_q <= 1'b0;
					end else begin
						state_q <= S_CHECK;
					end
				end
				S_MUL: begin
					if (step_q == MS_WY_ACC) begin
						state_q <= closing_q ? S_AREA : S_CHECK;
					end else begin
						step_q <= mstep_t'(step_q + 1'b1);
					end
				end
				S_CHECK: begin
					if (!stat.last) begin
						state_q <= S_IDLE;
					end else if (stat.overflowed || !stat.count_ge3) begin
						state_q <= S_RESULT;
					end else begin
						state_q   <= S_MUL;
						step_q    <= MS_P_XY;
						closing_q <= 1'b1;
					end
				end
				S_AREA:  state_q <= stat.cross_zero ? S_RESULT : S_DSTX;
				S_DSTX:  state_q <= S_DIVX;
				S_DIVX: begin
					if (stat.div_done) state_q <= S_DIVY;
				end
				S_DIVY: begin
					if (stat.div_done) state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (stat.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign vertex_stall = (state_q != S_IDLE);

endmodule

`default_nettype wire

### src/polygon_centroid.sv
// polygon centroid top level: controller and datapath
// depends on pc_pkg, pc_ctrl, pc_dp
`timescale 1ns / 1ps
`default_nettype none

// Shoelace centroid of a polygon sent one vertex per transfer, signed Q8.8 relative to
// the origin registers, last_vertex on the final one. One vertex is taken at a time:
// the first vertex of a polygon, and any vertex past MAX_VERTICES, skips the edge sequence,
// and every other one runs it on the single shared 17x17 multiplier
// (two cross products, four partial products of the weighted sums). The final vertex of
// a polygon with three or more vertices adds the closing edge and, for a nonzero area, two
// bit-serial divides before the result load; a polygon of one or two vertices, a zero area
// or too many vertices loads the result with no divides. The result waits in an output
// register and the next vertex is taken while it is still stalled.

module polygon_centroid
	import pc_pkg::*;
#(
	parameter int MAX_VERTICES = 1024,
	parameter int COORD_WIDTH  = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_index,
	input  wire logic [CW-1:0]        cfg_data,
	input  wire logic                 vertex_valid,
	output logic                      vertex_stall,
	input  wire logic signed [CW-1:0] vertex_x,
	input  wire logic signed [CW-1:0] vertex_y,
	input  wire logic                 last_vertex,
	output logic                      centroid_valid,
	input  wire logic                 centroid_stall,
	output logic signed [CW-1:0]      centroid_x,
	output logic signed [CW-1:0]      centroid_y,
	output logic [1:0]                status,
	output logic [CNT_W-1:0]          vertices_seen
);

	pc_cmd_t  cmd;
	pc_stat_t stat;

	pc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.vertex_valid (vertex_valid),
		.stat         (stat),
		.cmd          (cmd),
		.vertex_stall (vertex_stall)
	);

	pc_dp #(
		.MAX_VERTICES (MAX_VERTICES),
		.COORD_WIDTH  (COORD_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.vertex_x       (vertex_x),
		.vertex_y       (vertex_y),
		.last_vertex    (last_vertex),
		.centroid_stall (centroid_stall),
		.centroid_valid (centroid_valid),
		.centroid_x     (centroid_x),
		.centroid_y     (centroid_y),
		.status         (status),
		.vertices_seen  (vertices_seen),
		.cmd            (cmd),
		.stat           (stat)
	);

endmodule

`default_nettype wire

### src/pc_checker.sv
// port-level assertions for polygon_centroid, bound to the top level
// depends on pc_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module pc_checker
	import pc_pkg::*;
#(
	parameter int MAX_VERTICES = 1024
) (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             vertex_valid,
	input wire logic             vertex_stall,
	input wire logic             centroid_valid,
	input wire logic             centroid_stall,
	input wire logic [1:0]       status,
	input wire logic [CNT_W-1:0] vertices_seen
);

	`PC_ASSERT_NXT(a_out_hold, centroid_valid && centroid_stall, centroid_valid, "result dropped while stalled")
	`PC_ASSERT_NXT(a_busy_after_in, vertex_valid && !vertex_stall, vertex_stall, "vertex taken back to back")
	`PC_ASSERT_IMP(a_count_nonzero, centroid_valid, vertices_seen != '0, "result with no vertices")
	`PC_ASSERT_IMP(a_ovf_count, centroid_valid && (status == ST_OVERFLOW), vertices_seen == CNT_W'(MAX_VERTICES), "overflow without full count")
	`PC_ASSERT_IMP(a_zero_area_count, centroid_valid && (status == ST_ZERO_AREA), vertices_seen >= CNT_W'(3), "zero area below three vertices")

endmodule

bind polygon_centroid pc_checker #(
	.MAX_VERTICES (MAX_VERTICES)
) u_pc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.vertex_valid   (vertex_valid),
	.vertex_stall   (vertex_stall),
	.centroid_valid (centroid_valid),
	.centroid_stall (centroid_stall),
	.status         (status),
	.vertices_seen  (vertices_seen)
);

`default_nettype wire

### sim/polygon_centroid_test.sv
// self-checking bench for polygon_centroid: directed and random polygons under idle and stall
// depends on pc_pkg and the polygon_centroid rtl; the expected centroids come from its own model
`timescale 1ns / 1ps

module polygon_centroid_test;
	import pc_pkg::*;

	localparam int MAX_VERTS    = 1024;
	localparam int DRAIN_CYCLES = 300;
	localparam int PHASE_ITEMS  = 120;
	localparam int NUM_PHASES   = 6;

	localparam logic signed [CW-1:0] CORNER_VALS [6] = '{
		16'sh8000, 16'sh8001, 16'shffff, 16'sh0000, 16'sh0001, 16'sh7fff
	};

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic                 last;
	} vertex_item_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		status_t              status;
		logic [CNT_W-1:0]     seen;
	} centroid_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_ORIGIN_X;
	logic [CW-1:0] cfg_data = '0;
	logic vertex_valid = 1'b0;
	logic vertex_stall;
	logic signed [CW-1:0] vertex_x = '0;
	logic signed [CW-1:0] vertex_y = '0;
	logic last_vertex = 1'b0;
	logic centroid_valid;
	logic centroid_stall = 1'b0;
	logic signed [CW-1:0] centroid_x;
	logic signed [CW-1:0] centroid_y;
	logic [1:0] status;
	logic [CNT_W-1:0] vertices_seen;

	vertex_item_t   vertex_pending[$];
	centroid_item_t centroid_expected[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;

	// shoelace model state
	logic signed [CW-1:0] origin_x = '0;
	logic signed [CW-1:0] origin_y = '0;
	longint poly_first_x, poly_first_y, poly_prev_x, poly_prev_y;
	int     poly_count = 0;
	bit     poly_overflow = 1'b0;
	longint cross_acc = 0;
	longint wx_acc = 0;
	longint wy_acc = 0;

	polygon_centroid #(
		.MAX_VERTICES(MAX_VERTS),
		.COORD_WIDTH (CW)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.vertex_valid  (vertex_valid),
		.vertex_stall  (vertex_stall),
		.vertex_x      (vertex_x),
		.vertex_y      (vertex_y),
		.last_vertex   (last_vertex),
		.centroid_valid(centroid_valid),
		.centroid_stall(centroid_stall),
		.centroid_x    (centroid_x),
		.centroid_y    (centroid_y),
		.status        (status),
		.vertices_seen (vertices_seen)
	);

	always #5 clk = ~clk;

	// round to nearest, ties away from zero
	function automatic longint div_nearest(input longint n, input longint d);
		longint unsigned un, ud, q;
		un = (n < 0) ? -n : n;
		ud = (d < 0) ? -d : d;
		q = (64'd2 * un + ud) / (64'd2 * ud);
		return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic signed [CW-1:0] sat16(input longint v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return v[CW-1:0];
	endfunction

	function automatic void add_shoelace_edge(input longint x0, y0, x1, y1);
		longint c;
		c = x0 * y1 - x1 * y0;
		cross_acc += c;
		wx_acc += (x0 + x1) * c;
		wy_acc += (y0 + y1) * c;
	endfunction

	task automatic track_vertex(input logic signed [CW-1:0] vx, vy, input logic vlast);
		longint x, y, cx, cy;
		status_t st;
		centroid_item_t r;
		x = $signed(vx);
		y = $signed(vy);
		cx = 0;
		cy = 0;
		st = ST_OK;
		if (poly_count >= MAX_VERTS) begin
			poly_overflow = 1'b1;
		end else begin
			if (poly_count == 0) begin
				poly_first_x = x;
				poly_first_y = y;
			end else begin
				add_shoelace_edge(poly_prev_x, poly_prev_y, x, y);
			end
			poly_prev_x = x;
			poly_prev_y = y;
			poly_count++;
		end
		if (vlast) begin
			if (poly_overflow) begin
				st = ST_OVERFLOW;
			end else if (poly_count == 2) begin
				cx = div_nearest(poly_first_x + poly_prev_x, 2);
				cy = div_nearest(poly_first_y + poly_prev_y, 2);
			end else if (poly_count >= 3) begin
				add_shoelace_edge(poly_prev_x, poly_prev_y, poly_first_x, poly_first_y);
				if (cross_acc == 0) begin
					st = ST_ZERO_AREA;
				end else begin
					cx = div_nearest(wx_acc, 3 * cross_acc);
					cy = div_nearest(wy_acc, 3 * cross_acc);
				end
			end
			r.x = sat16(cx + longint'(origin_x));
			r.y = sat16(cy + longint'(origin_y));
			r.status = st;
			r.seen = poly_count[CNT_W-1:0];
			centroid_expected = {centroid_expected, r};
			poly_first_x = 0;
			poly_first_y = 0;
			poly_prev_x = 0;
			poly_prev_y = 0;
			poly_count = 0;
			poly_overflow = 1'b0;
			cross_acc = 0;
			wx_acc = 0;
			wy_acc = 0;
		end
	endtask

	// vertex driver
	always @(posedge clk or negedge arst_n) begin
		vertex_item_t nxt;
		if (!arst_n) begin
			vertex_valid <= 1'b0;
		end else begin
			if (vertex_valid && !vertex_stall)
				track_vertex(vertex_x, vertex_y, last_vertex);
			if (!vertex_valid || !vertex_stall) begin
				if (vertex_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = vertex_pending.pop_front();
					vertex_valid <= 1'b1;
					vertex_x <= nxt.x;
					vertex_y <= nxt.y;
					last_vertex <= nxt.last;
				end else begin
					vertex_valid <= 1'b0;
				end
			end
		end
	end

	// centroid monitor
	always @(posedge clk or negedge arst_n) begin
		centroid_item_t e;
		if (!arst_n) begin
			centroid_stall <= 1'b0;
		end else begin
			if (centroid_valid && !centroid_stall) begin
				if (centroid_expected.size() == 0) begin
					if (mismatch_count < 10)
						$display("error: centroid transfer with none expected, x %0d y %0d",
							centroid_x, centroid_y);
					mismatch_count++;
				end else begin
					e = centroid_expected.pop_front();
					if (centroid_x !== e.x || centroid_y !== e.y || status !== e.status ||
						vertices_seen !== e.seen) begin
						if (mismatch_count < 10)
							$display({"error: got x %0d y %0d status %0d seen %0d, ",
								"expected x %0d y %0d status %0d seen %0d"},
								centroid_x, centroid_y, status, vertices_seen,
								e.x, e.y, e.status, e.seen);
						mismatch_count++;
					end
				end
			end
			centroid_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic push_vertex(input logic signed [CW-1:0] x, y, input logic last);
		vertex_item_t v;
		v.x = x;
		v.y = y;
		v.last = last;
		vertex_pending = {vertex_pending, v};
	endtask

	// kind 0 full range, 1 small, 2 collinear, 3 corner values
	task automatic push_polygon(input int n, input int kind);
		int bx, by, dx, dy, k;
		logic signed [CW-1:0] x, y;
		bx = int'($urandom_range(2000)) - 1000;
		by = int'($urandom_range(2000)) - 1000;
		dx = int'($urandom_range(200)) - 100;
		dy = int'($urandom_range(200)) - 100;
		for (int i = 0; i < n; i++) begin
			case (kind)
			0: begin
				x = CW'($urandom());
				y = CW'($urandom());
			end
			1: begin
				x = CW'(int'($urandom_range(4095)) - 2048);
				y = CW'(int'($urandom_range(4095)) - 2048);
			end
			2: begin
				k = int'($urandom_range(16)) - 8;
				x = CW'(bx + k * dx);
				y = CW'(by + k * dy);
			end
			default: begin
				x = CORNER_VALS[$urandom_range(5)];
				y = CORNER_VALS[$urandom_range(5)];
			end
			endcase
			push_vertex(x, y, i == n - 1);
		end
	endtask

	task automatic push_random_polygons(input int target);
		int pushed, n, r, kind;
		pushed = 0;
		while (pushed < target) begin
			r = $urandom_range(99);
			if (r < 8)
				n = 1;
			else if (r < 16)
				n = 2;
			else if (r < 88)
				n = $urandom_range(8, 3);
			else
				n = $urandom_range(40, 9);
			r = $urandom_range(99);
			kind = (r < 35) ? 0 : (r < 70) ? 1 : (r < 85) ? 2 : 3;
			push_polygon(n, kind);
			pushed += n;
		end
	endtask

	task automatic settle();
		while (vertex_pending.size() != 0 || vertex_valid || centroid_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_origin(input logic signed [CW-1:0] ox, oy);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_ORIGIN_X;
		cfg_data <= ox;
		@(posedge clk);
		cfg_index <= REG_ORIGIN_Y;
		cfg_data <= oy;
		@(posedge clk);
		cfg_we <= 1'b0;
		origin_x = ox;
		origin_y = oy;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single vertex, midpoints with ties both ways, triangles, zero area
		push_vertex(16'sh7fff, 16'sh8000, 1'b1);
		push_vertex(16'sd1, 16'sd2, 1'b0);
		push_vertex(16'sd2, 16'sd3, 1'b1);
		push_vertex(-16'sd1, -16'sd2, 1'b0);
		push_vertex(-16'sd2, -16'sd3, 1'b1);
		push_vertex(16'sh7fff, 16'sh7fff, 1'b0);
		push_vertex(16'sh8000, 16'sh8000, 1'b1);
		push_vertex(16'sd0, 16'sd0, 1'b0);
		push_vertex(16'sd256, 16'sd0, 1'b0);
		push_vertex(16'sd0, 16'sd256, 1'b1);
		push_vertex(16'sd0, 16'sd0, 1'b0);
		push_vertex(16'sd256, 16'sd256, 1'b0);
		push_vertex(16'sd512, 16'sd512, 1'b1);
		push_vertex(16'sh8000, 16'sh8000, 1'b0);
		push_vertex(16'sh7fff, 16'sh8000, 1'b0);
		push_vertex(16'sh7fff, 16'sh7fff, 1'b1);
		push_vertex(16'sd5, 16'sd5, 1'b0);
		push_vertex(16'sd5, 16'sd5, 1'b0);
		push_vertex(16'sd5, 16'sd5, 1'b1);
		push_random_polygons(PHASE_ITEMS);

		for (int ph = 1; ph < NUM_PHASES; ph++) begin
			settle();
			case (ph)
			1: write_origin(16'sh7fff, 16'sh8000);
			2: write_origin(16'sh8000, 16'sh7fff);
			4: write_origin(16'sh0000, 16'sh0000);
			5: write_origin(CW'(int'($urandom_range(2047)) - 1024),
				CW'(int'($urandom_range(2047)) - 1024));
			default: write_origin(CW'($urandom()), CW'($urandom()));
			endcase
			case (ph % 4)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 60;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 60;
			end
			default: begin
				send_idle_pct = 32;
				recv_stall_pct = 32;
			end
			endcase
			push_random_polygons(PHASE_ITEMS);
			// one vertex past the limit on a collinear set
			if (ph == 4)
				push_polygon(MAX_VERTS + 1, 2);
		end

		settle();
		if (mismatch_count == 0)
			$display("polygon_centroid: match");
		else
			$display("polygon_centroid: mismatch");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("polygon_centroid: mismatch");
		$finish;
	end

endmodule
